[src/psl_pkg.sv]
// Shared types and constants for the power state lock controller.
package psl_pkg;

   localparam int LOCK_SLOTS = 16;
   localparam int SLOT_IDX_W = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;
   localparam int CSR_ADDR_W = 4;

   localparam logic [1:0]  LEVEL_RUN        = 2'd0;
   localparam logic [1:0]  LEVEL_IDLE       = 2'd1;
   localparam logic [1:0]  LEVEL_SLEEP      = 2'd2;
   localparam logic [1:0]  LEVEL_DEEP       = 2'd3;
   localparam logic [31:0] BUDGET_EXTERNAL  = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      MODE_TICK    = 3'd0,
      MODE_REQUEST = 3'd1,
      MODE_LOCK    = 3'd2,
      MODE_UNLOCK  = 3'd3,
      MODE_IDLE    = 3'd4,
      MODE_PREPARE = 3'd5,
      MODE_RESTORE = 3'd6,
      MODE_CLEAR   = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      CSR_FLOOR   = 2'd0,
      CSR_TWAKE   = 2'd1,
      CSR_TIMEOUT = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_APPLY,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [1:0]  target_state;
      logic [31:0] release_handle;
      logic [1:0]  query_state;
   } req_type;

   typedef struct packed {
      logic        error_flag;
      logic [1:0]  level_now;
      logic [1:0]  level_before;
      logic [31:0] granted_handle;
      logic [31:0] sleep_budget_ms;
      logic [31:0] transitions_total;
      logic [31:0] wakes_total;
      logic [31:0] time_in_query_ms;
   } rsp_type;

endpackage

[src/psl_ram.sv]
// Generic single-port-write, registered-read RAM.
module psl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[src/power_state_lock_controller.sv]
// Top level of the power state lock controller: sequencer, lock scan and level logic.
//
// Each item (one power event) starts with start high while busy is low and yields
// exactly one result, shown for one cycle with rsp_valid high; the receiver cannot
// stall it. The lock table sits in a RAM with one registered read port, and the
// sequencer walks it one slot per cycle to find the shallowest active lock, the
// first free slot and the lock to release, then applies the event and presents
// the result. No clearing pass runs after reset.
module power_state_lock_controller (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  psl_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   output psl_pkg::rsp_type                   rsp_data,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [psl_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   typedef struct packed {
      logic [1:0]  level;
      logic [31:0] handle;
   } slot_entry_type;

   typedef struct packed {
      logic [1:0]  cur;
      logic [1:0]  prev;
      logic [31:0] tcnt;
   } lvl_state_type;

   localparam int IW = psl_pkg::SLOT_IDX_W;

   function automatic lvl_state_type go_level(lvl_state_type s, logic [1:0] lvl,
                                              logic [1:0] lim);
      lvl_state_type r;
      logic [1:0]    t;
      r = s;
      t = (lvl > lim) ? lim : lvl;
      if (lvl != s.cur && t != s.cur) begin
         r.prev = s.cur;
         r.cur  = t;
         r.tcnt = s.tcnt + 32'd1;
      end
      return r;
   endfunction

   psl_pkg::state_type state_ff, state_in;

   psl_pkg::req_type    item_ff, item_in;
   logic [IW-1:0]       idx_ff, idx_in;
   logic                chk_vld_ff, chk_vld_in;
   logic [IW-1:0]       chk_idx_ff, chk_idx_in;
   logic [1:0]          min_ff, min_in;
   logic                free_fnd_ff, free_fnd_in;
   logic [IW-1:0]       free_idx_ff, free_idx_in;
   logic                match_fnd_ff, match_fnd_in;
   logic [IW-1:0]       match_idx_ff, match_idx_in;

   logic [psl_pkg::LOCK_SLOTS-1:0] active_ff, active_in;
   logic [31:0]         next_handle_ff, next_handle_in;
   logic [1:0]          cur_ff, cur_in;
   logic [1:0]          prev_ff, prev_in;
   logic [1:0]          wanted_ff, wanted_in;
   logic [31:0]         tcnt_ff, tcnt_in;
   logic [31:0]         wcnt_ff, wcnt_in;
   logic [31:0]         ltime_ff [4];
   logic [31:0]         ltime_in [4];

   logic                err_ff, err_in;
   logic [31:0]         granted_ff, granted_in;
   logic [31:0]         budget_ff, budget_in;

   logic [1:0]          floor_ff, floor_in;
   logic                twake_ff, twake_in;
   logic [31:0]         tmo_ff, tmo_in;

   logic                ram_wr_en;
   slot_entry_type      ram_wr_data;
   slot_entry_type      ram_rd_data;
   logic [IW-1:0]       ram_wr_addr;

   logic                csr_write;
   logic [1:0]          lim;
   logic [31:0]         nh_inc;
   lvl_state_type       ls;

   psl_ram #(
      .WIDTH ($bits(slot_entry_type)),
      .DEPTH (psl_pkg::LOCK_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign busy      = (state_ff != psl_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == psl_pkg::ST_DONE);

   always_comb begin
      rsp_data.error_flag        = err_ff;
      rsp_data.level_now         = cur_ff;
      rsp_data.level_before      = prev_ff;
      rsp_data.granted_handle    = granted_ff;
      rsp_data.sleep_budget_ms   = budget_ff;
      rsp_data.transitions_total = tcnt_ff;
      rsp_data.wakes_total       = wcnt_ff;
      rsp_data.time_in_query_ms  = ltime_ff[item_ff.query_state];
   end

   always_comb begin
      unique case (psl_pkg::csr_index_type'(paddr[3:2]))
         psl_pkg::CSR_FLOOR:   prdata = {30'd0, floor_ff};
         psl_pkg::CSR_TWAKE:   prdata = {31'd0, twake_ff};
         psl_pkg::CSR_TIMEOUT: prdata = tmo_ff;
         default:              prdata = 32'd0;
      endcase
   end

   always_comb begin
      floor_in = floor_ff;
      twake_in = twake_ff;
      tmo_in   = tmo_ff;
      if (csr_write) begin
         unique case (psl_pkg::csr_index_type'(paddr[3:2]))
            psl_pkg::CSR_FLOOR:   floor_in = pwdata[1:0];
            psl_pkg::CSR_TWAKE:   twake_in = pwdata[0];
            psl_pkg::CSR_TIMEOUT: tmo_in   = pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      idx_in         = idx_ff;
      chk_vld_in     = 1'b0;
      chk_idx_in     = idx_ff;
      min_in         = min_ff;
      free_fnd_in    = free_fnd_ff;
      free_idx_in    = free_idx_ff;
      match_fnd_in   = match_fnd_ff;
      match_idx_in   = match_idx_ff;
      active_in      = active_ff;
      next_handle_in = next_handle_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      wanted_in      = wanted_ff;
      tcnt_in        = tcnt_ff;
      wcnt_in        = wcnt_ff;
      ltime_in       = ltime_ff;
      err_in         = err_ff;
      granted_in     = granted_ff;
      budget_in      = budget_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = free_idx_ff;
      ram_wr_data.level  = item_ff.target_state;
      ram_wr_data.handle = next_handle_ff;
      lim            = (floor_ff < min_ff) ? floor_ff : min_ff;
      nh_inc         = next_handle_ff + 32'd1;
      ls.cur         = cur_ff;
      ls.prev        = prev_ff;
      ls.tcnt        = tcnt_ff;

      // evaluate the slot read in the previous cycle
      if (chk_vld_ff) begin
         if (!active_ff[chk_idx_ff]) begin
            if (!free_fnd_ff) begin
               free_fnd_in = 1'b1;
               free_idx_in = chk_idx_ff;
            end
         end else if (item_ff.mode == psl_pkg::MODE_UNLOCK && !match_fnd_ff &&
                      item_ff.release_handle != 32'd0 &&
                      ram_rd_data.handle == item_ff.release_handle) begin
            match_fnd_in = 1'b1;
            match_idx_in = chk_idx_ff;
         end else if (ram_rd_data.level < min_ff) begin
            min_in = ram_rd_data.level;
         end
      end

      unique case (state_ff)
         psl_pkg::ST_IDLE: begin
            if (start) begin
               item_in      = req_data;
               idx_in       = '0;
               min_in       = psl_pkg::LEVEL_DEEP;
               free_fnd_in  = 1'b0;
               match_fnd_in = 1'b0;
               state_in     = psl_pkg::ST_SCAN;
            end
         end
         psl_pkg::ST_SCAN: begin
            chk_vld_in = 1'b1;
            chk_idx_in = idx_ff;
            if (idx_ff == IW'(psl_pkg::LOCK_SLOTS - 1)) begin
               state_in = psl_pkg::ST_DRAIN;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         psl_pkg::ST_DRAIN: begin
            state_in = psl_pkg::ST_APPLY;
         end
         psl_pkg::ST_APPLY: begin
            err_in     = 1'b0;
            granted_in = 32'd0;
            budget_in  = 32'd0;
            unique case (psl_pkg::mode_type'(item_ff.mode))
               psl_pkg::MODE_TICK: begin
                  for (int k = 0; k < 4; k++) begin
                     if (cur_ff == 2'(k)) begin
                        ltime_in[k] = ltime_ff[k] + 32'd1;
                     end
                  end
               end
               psl_pkg::MODE_REQUEST: begin
                  wanted_in = item_ff.target_state;
                  ls = go_level(ls, item_ff.target_state, lim);
               end
               psl_pkg::MODE_LOCK: begin
                  err_in = !free_fnd_ff;
                  if (free_fnd_ff) begin
                     granted_in     = next_handle_ff;
                     next_handle_in = (nh_inc == 32'd0) ? 32'd1 : nh_inc;
                     ram_wr_en      = 1'b1;
                     active_in[free_idx_ff] = 1'b1;
                     if (cur_ff > item_ff.target_state) begin
                        ls = go_level(ls, item_ff.target_state,
                                      (item_ff.target_state < lim) ?
                                      item_ff.target_state : lim);
                     end
                  end
               end
               psl_pkg::MODE_UNLOCK: begin
                  err_in = !match_fnd_ff;
                  if (match_fnd_ff) begin
                     active_in[match_idx_ff] = 1'b0;
                     if (wanted_ff > cur_ff) begin
                        ls = go_level(ls, wanted_ff, lim);
                     end
                  end
               end
               psl_pkg::MODE_IDLE: begin
                  if (cur_ff != psl_pkg::LEVEL_IDLE) begin
                     ls = go_level(ls, psl_pkg::LEVEL_IDLE, lim);
                  end
                  wcnt_in = wcnt_ff + 32'd1;
                  ls = go_level(ls, psl_pkg::LEVEL_RUN, lim);
               end
               psl_pkg::MODE_PREPARE: begin
                  if (lim >= psl_pkg::LEVEL_SLEEP) begin
                     ls = go_level(ls, psl_pkg::LEVEL_SLEEP, lim);
                     budget_in = twake_ff ? tmo_ff : psl_pkg::BUDGET_EXTERNAL;
                  end
               end
               psl_pkg::MODE_RESTORE: begin
                  wcnt_in = wcnt_ff + 32'd1;
                  ls = go_level(ls, psl_pkg::LEVEL_RUN, lim);
               end
               psl_pkg::MODE_CLEAR: begin
                  for (int k = 0; k < 4; k++) begin
                     ltime_in[k] = 32'd0;
                  end
                  wcnt_in = 32'd0;
                  ls.tcnt = 32'd0;
               end
               default: ;
            endcase
            cur_in   = ls.cur;
            prev_in  = ls.prev;
            tcnt_in  = ls.tcnt;
            state_in = psl_pkg::ST_DONE;
         end
         psl_pkg::ST_DONE: begin
            state_in = psl_pkg::ST_IDLE;
         end
         default: begin
            state_in = psl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= psl_pkg::ST_IDLE;
         chk_vld_ff     <= 1'b0;
         active_ff      <= '0;
         next_handle_ff <= 32'd1;
         cur_ff         <= psl_pkg::LEVEL_RUN;
         prev_ff        <= psl_pkg::LEVEL_RUN;
         wanted_ff      <= psl_pkg::LEVEL_RUN;
         tcnt_ff        <= 32'd0;
         wcnt_ff        <= 32'd0;
         for (int k = 0; k < 4; k++) begin
            ltime_ff[k] <= 32'd0;
         end
         floor_ff       <= psl_pkg::LEVEL_DEEP;
         twake_ff       <= 1'b0;
         tmo_ff         <= 32'd0;
      end else begin
         state_ff       <= state_in;
         chk_vld_ff     <= chk_vld_in;
         active_ff      <= active_in;
         next_handle_ff <= next_handle_in;
         cur_ff         <= cur_in;
         prev_ff        <= prev_in;
         wanted_ff      <= wanted_in;
         tcnt_ff        <= tcnt_in;
         wcnt_ff        <= wcnt_in;
         ltime_ff       <= ltime_in;
         floor_ff       <= floor_in;
         twake_ff       <= twake_in;
         tmo_ff         <= tmo_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      idx_ff       <= idx_in;
      chk_idx_ff   <= chk_idx_in;
      min_ff       <= min_in;
      free_fnd_ff  <= free_fnd_in;
      free_idx_ff  <= free_idx_in;
      match_fnd_ff <= match_fnd_in;
      match_idx_ff <= match_idx_in;
      err_ff       <= err_in;
      granted_ff   <= granted_in;
      budget_ff    <= budget_in;
   end

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the power state lock controller: directed and random power events.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           start = 1'b0;
   logic                           busy;
   psl_pkg::req_type               req_data = '0;
   logic                           rsp_valid;
   psl_pkg::rsp_type               rsp_data;
   logic                           psel = 1'b0;
   logic                           penable = 1'b0;
   logic                           pwrite = 1'b0;
   logic [psl_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]                    pwdata = '0;
   logic [31:0]                    prdata;
   logic                           pready;

   // power controller state as predicted by the testbench
   bit          lock_live [psl_pkg::LOCK_SLOTS];
   logic [31:0] lock_key [psl_pkg::LOCK_SLOTS];
   logic [1:0]  lock_depth [psl_pkg::LOCK_SLOTS];
   logic [31:0] handle_next = 32'd1;
   logic [1:0]  level_cur = psl_pkg::LEVEL_RUN;
   logic [1:0]  level_prev = psl_pkg::LEVEL_RUN;
   logic [1:0]  level_want = psl_pkg::LEVEL_RUN;
   logic [31:0] trans_count = '0;
   logic [31:0] wake_tally = '0;
   logic [31:0] dwell [4] = '{default: '0};
   logic [1:0]  floor_cfg = psl_pkg::LEVEL_DEEP;
   logic        twake_cfg = 1'b0;
   logic [31:0] timeout_cfg = '0;

   psl_pkg::rsp_type expected_status [$];
   int               mismatch_count = 0;

   power_state_lock_controller DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Test completed with failures");
      $finish;
   end

   function automatic logic [1:0] allowed_depth();
      logic [1:0] lim;
      lim = psl_pkg::LEVEL_DEEP;
      for (int i = 0; i < psl_pkg::LOCK_SLOTS; i++)
         if (lock_live[i] && lock_depth[i] < lim) lim = lock_depth[i];
      if (floor_cfg < lim) lim = floor_cfg;
      return lim;
   endfunction

   function automatic void move_to(logic [1:0] lvl);
      logic [1:0] lim;
      if (lvl == level_cur) return;
      lim = allowed_depth();
      if (lvl > lim) lvl = lim;
      if (lvl == level_cur) return;
      level_prev = level_cur;
      level_cur = lvl;
      trans_count++;
   endfunction

   function automatic psl_pkg::rsp_type apply_event(psl_pkg::req_type item);
      psl_pkg::rsp_type r;
      r = '0;
      case (item.mode)
         psl_pkg::MODE_TICK: dwell[level_cur]++;
         psl_pkg::MODE_REQUEST: begin
            level_want = item.target_state;
            move_to(item.target_state);
         end
         psl_pkg::MODE_LOCK: begin
            r.error_flag = 1'b1;
            for (int i = 0; i < psl_pkg::LOCK_SLOTS; i++)
               if (r.error_flag && !lock_live[i]) begin
                  r.granted_handle = handle_next;
                  handle_next++;
                  if (handle_next == 32'd0) handle_next = 32'd1;
                  lock_key[i] = r.granted_handle;
                  lock_depth[i] = item.target_state;
                  lock_live[i] = 1'b1;
                  r.error_flag = 1'b0;
                  if (level_cur > item.target_state) move_to(item.target_state);
               end
         end
         psl_pkg::MODE_UNLOCK: begin
            r.error_flag = 1'b1;
            if (item.release_handle != 32'd0)
               for (int i = 0; i < psl_pkg::LOCK_SLOTS; i++)
                  if (r.error_flag && lock_live[i] && lock_key[i] == item.release_handle) begin
                     lock_live[i] = 1'b0;
                     r.error_flag = 1'b0;
                     if (level_want > level_cur) move_to(level_want);
                  end
         end
         psl_pkg::MODE_IDLE: begin
            if (level_cur != psl_pkg::LEVEL_IDLE) move_to(psl_pkg::LEVEL_IDLE);
            wake_tally++;
            move_to(psl_pkg::LEVEL_RUN);
         end
         psl_pkg::MODE_PREPARE: begin
            if (allowed_depth() >= psl_pkg::LEVEL_SLEEP) begin
               move_to(psl_pkg::LEVEL_SLEEP);
               r.sleep_budget_ms = twake_cfg ? timeout_cfg : psl_pkg::BUDGET_EXTERNAL;
            end
         end
         psl_pkg::MODE_RESTORE: begin
            wake_tally++;
            move_to(psl_pkg::LEVEL_RUN);
         end
         default: begin
            dwell = '{default: '0};
            wake_tally = '0;
            trans_count = '0;
         end
      endcase
      r.level_now = level_cur;
      r.level_before = level_prev;
      r.transitions_total = trans_count;
      r.wakes_total = wake_tally;
      r.time_in_query_ms = dwell[item.query_state];
      return r;
   endfunction

   function automatic int live_locks();
      int n;
      n = 0;
      for (int i = 0; i < psl_pkg::LOCK_SLOTS; i++) n += lock_live[i];
      return n;
   endfunction

   function automatic logic [31:0] live_handle();
      int idx [$];
      for (int i = 0; i < psl_pkg::LOCK_SLOTS; i++)
         if (lock_live[i]) idx.push_back(i);
      if (idx.size() == 0) return $urandom();
      return lock_key[idx[$urandom_range(0, idx.size() - 1)]];
   endfunction

   function automatic psl_pkg::req_type make_item(psl_pkg::mode_type m, logic [1:0] tgt,
                                                  logic [31:0] rel, logic [1:0] q);
      psl_pkg::req_type item;
      item.mode = m;
      item.target_state = tgt;
      item.release_handle = rel;
      item.query_state = q;
      return item;
   endfunction

   function automatic psl_pkg::req_type random_event();
      psl_pkg::req_type item;
      int pick;
      int sel;
      item = make_item(psl_pkg::MODE_TICK, 2'($urandom_range(0, 3)), $urandom(),
                       2'($urandom_range(0, 3)));
      pick = $urandom_range(0, 99);
      if (pick < 20) item.mode = psl_pkg::MODE_TICK;
      else if (pick < 35) item.mode = psl_pkg::MODE_REQUEST;
      else if (pick < 50) item.mode = psl_pkg::MODE_LOCK;
      else if (pick < 67) begin
         item.mode = psl_pkg::MODE_UNLOCK;
         sel = $urandom_range(0, 19);
         if (sel == 0) item.release_handle = '0;
         else if (sel > 2) item.release_handle = live_handle();
      end
      else if (pick < 75) item.mode = psl_pkg::MODE_IDLE;
      else if (pick < 87) item.mode = psl_pkg::MODE_PREPARE;
      else if (pick < 97) item.mode = psl_pkg::MODE_RESTORE;
      else item.mode = psl_pkg::MODE_CLEAR;
      return item;
   endfunction

   task automatic send_event(input psl_pkg::req_type item);
      int gap;
      gap = $urandom_range(0, 5);
      @(posedge clock);
      if (gap > 0) begin
         while (busy) @(posedge clock);
         repeat (gap - 1) @(posedge clock);
      end
      req_data <= item;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      expected_status.push_back(apply_event(item));
      start <= 1'b0;
   endtask

   task automatic wait_drained();
      int waited;
      waited = 0;
      while ((expected_status.size() != 0 || busy) && waited < 1000) begin
         @(posedge clock);
         waited++;
      end
      if (expected_status.size() != 0 || busy) begin
         $display("%0t ns: results stopped arriving, %0d outstanding", $time,
                  expected_status.size());
         mismatch_count++;
      end
   endtask

   task automatic csr_write(psl_pkg::csr_index_type idx, logic [31:0] value);
      logic [31:0] mask;
      logic [31:0] want;
      logic [31:0] got;
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         psl_pkg::CSR_FLOOR: begin
            floor_cfg = value[1:0];
            mask = 32'h3;
            want = {30'd0, floor_cfg};
         end
         psl_pkg::CSR_TWAKE: begin
            twake_cfg = value[0];
            mask = 32'h1;
            want = {31'd0, twake_cfg};
         end
         default: begin
            timeout_cfg = value;
            mask = '1;
            want = timeout_cfg;
         end
      endcase
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata & mask;
      psel <= 1'b0;
      penable <= 1'b0;
      if (got !== want) begin
         $display("%0t ns: register %s read expected %h, got %h", $time, idx.name(), want, got);
         mismatch_count++;
      end
   endtask

   task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      psl_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_status.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, got %h", $time, rsp_data);
            mismatch_count++;
         end else begin
            want = expected_status.pop_front();
            report_field("error_flag", 32'(want.error_flag), 32'(rsp_data.error_flag));
            report_field("level_now", 32'(want.level_now), 32'(rsp_data.level_now));
            report_field("level_before", 32'(want.level_before),
                         32'(rsp_data.level_before));
            report_field("granted_handle", want.granted_handle, rsp_data.granted_handle);
            report_field("sleep_budget_ms", want.sleep_budget_ms, rsp_data.sleep_budget_ms);
            report_field("transitions_total", want.transitions_total,
                         rsp_data.transitions_total);
            report_field("wakes_total", want.wakes_total, rsp_data.wakes_total);
            report_field("time_in_query_ms", want.time_in_query_ms, rsp_data.time_in_query_ms);
         end
      end
   end

   task automatic test_event_modes();
      send_event(make_item(psl_pkg::MODE_TICK, psl_pkg::LEVEL_RUN, 32'h0, psl_pkg::LEVEL_RUN));
      send_event(make_item(psl_pkg::MODE_REQUEST, psl_pkg::LEVEL_DEEP, 32'hFFFF_FFFF,
                           psl_pkg::LEVEL_DEEP));
      send_event(make_item(psl_pkg::MODE_TICK, psl_pkg::LEVEL_RUN, 32'h0, psl_pkg::LEVEL_DEEP));
      send_event(make_item(psl_pkg::MODE_REQUEST, psl_pkg::LEVEL_RUN, 32'h0,
                           psl_pkg::LEVEL_RUN));
      send_event(make_item(psl_pkg::MODE_LOCK, psl_pkg::LEVEL_IDLE, 32'h0, psl_pkg::LEVEL_IDLE));
      send_event(make_item(psl_pkg::MODE_REQUEST, psl_pkg::LEVEL_DEEP, 32'h0,
                           psl_pkg::LEVEL_RUN));
      send_event(make_item(psl_pkg::MODE_PREPARE, psl_pkg::LEVEL_RUN, 32'h0,
                           psl_pkg::LEVEL_IDLE));
      send_event(make_item(psl_pkg::MODE_UNLOCK, psl_pkg::LEVEL_RUN, 32'h0, psl_pkg::LEVEL_RUN));
      send_event(make_item(psl_pkg::MODE_UNLOCK, psl_pkg::LEVEL_DEEP, 32'hFFFF_FFFF,
                           psl_pkg::LEVEL_DEEP));
      send_event(make_item(psl_pkg::MODE_UNLOCK, psl_pkg::LEVEL_RUN, 32'h1,
                           psl_pkg::LEVEL_IDLE));
      send_event(make_item(psl_pkg::MODE_PREPARE, psl_pkg::LEVEL_RUN, 32'h0,
                           psl_pkg::LEVEL_SLEEP));
      send_event(make_item(psl_pkg::MODE_TICK, psl_pkg::LEVEL_RUN, 32'h0, psl_pkg::LEVEL_SLEEP));
      send_event(make_item(psl_pkg::MODE_IDLE, psl_pkg::LEVEL_RUN, 32'h0, psl_pkg::LEVEL_IDLE));
      send_event(make_item(psl_pkg::MODE_IDLE, psl_pkg::LEVEL_RUN, 32'h0, psl_pkg::LEVEL_RUN));
      send_event(make_item(psl_pkg::MODE_LOCK, psl_pkg::LEVEL_RUN, 32'h0, psl_pkg::LEVEL_RUN));
      send_event(make_item(psl_pkg::MODE_REQUEST, psl_pkg::LEVEL_SLEEP, 32'h0,
                           psl_pkg::LEVEL_RUN));
      send_event(make_item(psl_pkg::MODE_IDLE, psl_pkg::LEVEL_RUN, 32'h0, psl_pkg::LEVEL_IDLE));
      send_event(make_item(psl_pkg::MODE_UNLOCK, psl_pkg::LEVEL_RUN, 32'h2, psl_pkg::LEVEL_RUN));
      send_event(make_item(psl_pkg::MODE_RESTORE, psl_pkg::LEVEL_RUN, 32'h0,
                           psl_pkg::LEVEL_SLEEP));
      send_event(make_item(psl_pkg::MODE_REQUEST, psl_pkg::LEVEL_DEEP, 32'h0,
                           psl_pkg::LEVEL_RUN));
      send_event(make_item(psl_pkg::MODE_LOCK, psl_pkg::LEVEL_SLEEP, 32'h0,
                           psl_pkg::LEVEL_DEEP));
      send_event(make_item(psl_pkg::MODE_TICK, psl_pkg::LEVEL_RUN, 32'h0, psl_pkg::LEVEL_SLEEP));
      send_event(make_item(psl_pkg::MODE_CLEAR, psl_pkg::LEVEL_DEEP, 32'hFFFF_FFFF,
                           psl_pkg::LEVEL_SLEEP));
      send_event(make_item(psl_pkg::MODE_TICK, psl_pkg::LEVEL_RUN, 32'h0, psl_pkg::LEVEL_SLEEP));
      send_event(make_item(psl_pkg::MODE_UNLOCK, psl_pkg::LEVEL_RUN, 32'h3,
                           psl_pkg::LEVEL_DEEP));
   endtask

   task automatic test_lock_table();
      while (live_locks() < psl_pkg::LOCK_SLOTS)
         send_event(make_item(psl_pkg::MODE_LOCK, 2'($urandom_range(0, 3)), $urandom(),
                              2'($urandom_range(0, 3))));
      repeat (2)
         send_event(make_item(psl_pkg::MODE_LOCK, 2'($urandom_range(0, 3)), $urandom(),
                              2'($urandom_range(0, 3))));
      send_event(make_item(psl_pkg::MODE_REQUEST, psl_pkg::LEVEL_DEEP, $urandom(),
                           psl_pkg::LEVEL_DEEP));
      while (live_locks() > 0) begin
         if ($urandom_range(0, 3) == 0)
            send_event(make_item(psl_pkg::MODE_UNLOCK, 2'($urandom_range(0, 3)), $urandom(),
                                 2'($urandom_range(0, 3))));
         send_event(make_item(psl_pkg::MODE_UNLOCK, 2'($urandom_range(0, 3)), live_handle(),
                              2'($urandom_range(0, 3))));
         send_event(make_item(psl_pkg::MODE_TICK, 2'($urandom_range(0, 3)), $urandom(),
                              2'($urandom_range(0, 3))));
      end
   endtask

   task automatic test_register_settings();
      for (int f = 0; f < 4; f++) begin
         wait_drained();
         csr_write(psl_pkg::CSR_FLOOR, f);
         csr_write(psl_pkg::CSR_TWAKE, f % 2);
         csr_write(psl_pkg::CSR_TIMEOUT,
                   (f == 1) ? 32'hFFFF_FFFF : (f == 3) ? 32'h0 : $urandom());
         send_event(make_item(psl_pkg::MODE_REQUEST, psl_pkg::LEVEL_DEEP, $urandom(),
                              2'($urandom_range(0, 3))));
         send_event(make_item(psl_pkg::MODE_TICK, 2'($urandom_range(0, 3)), $urandom(),
                              2'(f)));
         send_event(make_item(psl_pkg::MODE_PREPARE, 2'($urandom_range(0, 3)), $urandom(),
                              psl_pkg::LEVEL_SLEEP));
         send_event(make_item(psl_pkg::MODE_TICK, 2'($urandom_range(0, 3)), $urandom(),
                              psl_pkg::LEVEL_SLEEP));
         send_event(make_item(psl_pkg::MODE_RESTORE, 2'($urandom_range(0, 3)), $urandom(),
                              psl_pkg::LEVEL_RUN));
      end
   endtask

   task automatic test_random_traffic();
      logic [31:0] timeout_pick [4];
      logic [1:0]  floor_pick [4];
      timeout_pick = '{$urandom(), 32'h0, 32'hFFFF_FFFF, $urandom()};
      floor_pick = '{psl_pkg::LEVEL_DEEP, psl_pkg::LEVEL_SLEEP, 2'($urandom_range(0, 3)),
                     psl_pkg::LEVEL_IDLE};
      for (int p = 0; p < 4; p++) begin
         wait_drained();
         csr_write(psl_pkg::CSR_FLOOR, 32'(floor_pick[p]));
         csr_write(psl_pkg::CSR_TWAKE, {31'd0, (p == 0 || p == 2)});
         csr_write(psl_pkg::CSR_TIMEOUT, timeout_pick[p]);
         repeat (500) send_event(random_event());
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_event_modes();
      test_lock_table();
      test_register_settings();
      test_random_traffic();
      wait_drained();
      repeat (psl_pkg::LOCK_SLOTS + 8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
